### rtl/core/qtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtt_pkg
// Shared widths, defaults, register indexes and types of the quality tail
// trimmer.
// ----------------------------------------------------------------------------
package qtt_pkg;

	localparam int QCHAR_W  = 8;
	localparam int THR_W    = 7;
	localparam int LEN_W    = 11;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 1;

	localparam int MAX_LEN_DEFAULT  = 1024;
	localparam int MIN_KEEP_DEFAULT = 36;

	localparam logic signed [QCHAR_W:0] OFFSET_SANGER = 9'sd64;
	localparam logic signed [QCHAR_W:0] OFFSET_STD    = 9'sd33;
	localparam logic [QCHAR_W-1:0]      SANGER_SHIFT  = 8'd31;

	localparam logic [CFG_IDX_W-1:0] CFG_TRIM_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SANGER_MODE    = 1'b1;

	typedef struct packed {
		logic [THR_W-1:0] trim_threshold;
		logic             sanger_mode;
	} cfg_t;

endpackage

### rtl/core/qtt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtt_if
// Valid/ready channels of the quality tail trimmer: character input and
// converted character with trim result output.
// ----------------------------------------------------------------------------
interface qtt_in_if;
	logic                         valid;
	logic                         ready;
	logic [qtt_pkg::QCHAR_W-1:0]  quality_char;
	logic                         last;

	modport source (output valid, output quality_char, output last, input ready);
	modport sink (input valid, input quality_char, input last, output ready);
endinterface

interface qtt_out_if;
	logic                         valid;
	logic                         ready;
	logic [qtt_pkg::QCHAR_W-1:0]  quality_out;
	logic                         trim_valid;
	logic [qtt_pkg::LEN_W-1:0]    trim_length;

	modport source (output valid, output quality_out, output trim_valid,
		output trim_length, input ready);
	modport sink (input valid, input quality_out, input trim_valid,
		input trim_length, output ready);
endinterface

### rtl/core/qtt_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtt_accum
// Per-read running sum of threshold minus quality and first-minimum tracker,
// one character per step, with the stage-two result register.
// ----------------------------------------------------------------------------
module qtt_accum #(
	parameter int MAX_LEN = qtt_pkg::MAX_LEN_DEFAULT
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      step,
	input  qtt_pkg::cfg_t                             cfg,
	input  logic [qtt_pkg::QCHAR_W-1:0]               quality_char_s1,
	input  logic                                      last_s1,
	output logic [qtt_pkg::QCHAR_W-1:0]               quality_out_s2,
	output logic                                      last_s2,
	output logic                                      keep_all_s2,
	output logic signed [$clog2(MAX_LEN)+qtt_pkg::QCHAR_W:0] prefix_s2,
	output logic signed [$clog2(MAX_LEN)+qtt_pkg::QCHAR_W:0] min_prefix_s2,
	output logic [$clog2(MAX_LEN+1)-1:0]              min_pos_s2,
	output logic [$clog2(MAX_LEN+1)-1:0]              pos_s2
);
	import qtt_pkg::*;

	localparam int SUM_W = $clog2(MAX_LEN) + QCHAR_W + 1;
	localparam int POS_W = $clog2(MAX_LEN + 1);

	logic signed [SUM_W-1:0]  prefix_q, min_prefix_q;
	logic [POS_W-1:0]         min_pos_q, pos_q;

	logic signed [QCHAR_W:0]  q, thr, diff;
	logic                     counting, take, keep_all;
	logic [QCHAR_W-1:0]       qout;
	logic signed [SUM_W-1:0]  prefix_n, min_prefix_n;
	logic [POS_W-1:0]         min_pos_n, pos_n;

	always_comb begin
		q        = signed'({1'b0, quality_char_s1})
			- (cfg.sanger_mode ? OFFSET_SANGER : OFFSET_STD);
		thr      = signed'({2'b00, cfg.trim_threshold});
		diff     = thr - q;
		keep_all = (cfg.trim_threshold == '0) || (q >= thr);
		qout     = cfg.sanger_mode ? quality_char_s1 - SANGER_SHIFT : quality_char_s1;
		counting = pos_q < POS_W'(MAX_LEN);
		take     = counting && (pos_q != '0)
			&& ((min_pos_q == '0) || (prefix_q < min_prefix_q));
		min_prefix_n = take ? prefix_q : min_prefix_q;
		min_pos_n    = take ? pos_q : min_pos_q;
		prefix_n     = counting ? prefix_q + SUM_W'(diff) : prefix_q;
		pos_n        = counting ? pos_q + 1'b1 : pos_q;
	end

	// per-read state, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q     <= '0;
			min_prefix_q <= '0;
			min_pos_q    <= '0;
			pos_q        <= '0;
		end else if (step) begin
			if (last_s1) begin
				prefix_q     <= '0;
				min_prefix_q <= '0;
				min_pos_q    <= '0;
				pos_q        <= '0;
			end else begin
				prefix_q     <= prefix_n;
				min_prefix_q <= min_prefix_n;
				min_pos_q    <= min_pos_n;
				pos_q        <= pos_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			quality_out_s2 <= qout;
			last_s2        <= last_s1;
			keep_all_s2    <= keep_all;
			prefix_s2      <= prefix_n;
			min_prefix_s2  <= min_prefix_n;
			min_pos_s2     <= min_pos_n;
			pos_s2         <= pos_n;
		end
	end

endmodule

### rtl/core/qtt_len.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtt_len
// Kept-length decision for the last character of a read and the output
// result register.
// ----------------------------------------------------------------------------
module qtt_len #(
	parameter int MAX_LEN  = qtt_pkg::MAX_LEN_DEFAULT,
	parameter int MIN_KEEP = qtt_pkg::MIN_KEEP_DEFAULT
) (
	input  logic                                      clk,
	input  logic                                      step,
	input  logic [qtt_pkg::QCHAR_W-1:0]               quality_out_s2,
	input  logic                                      last_s2,
	input  logic                                      keep_all_s2,
	input  logic signed [$clog2(MAX_LEN)+qtt_pkg::QCHAR_W:0] prefix_s2,
	input  logic signed [$clog2(MAX_LEN)+qtt_pkg::QCHAR_W:0] min_prefix_s2,
	input  logic [$clog2(MAX_LEN+1)-1:0]              min_pos_s2,
	input  logic [$clog2(MAX_LEN+1)-1:0]              pos_s2,
	output logic [qtt_pkg::QCHAR_W-1:0]               quality_out_s3,
	output logic                                      trim_valid_s3,
	output logic [qtt_pkg::LEN_W-1:0]                 trim_length_s3
);
	import qtt_pkg::*;

	localparam int POS_W  = $clog2(MAX_LEN + 1);
	localparam int KEEP_W = (MIN_KEEP > 0) ? $clog2(MIN_KEEP + 1) : 1;
	localparam int CUT_W  = (KEEP_W > POS_W) ? KEEP_W : POS_W;

	logic [CUT_W-1:0] cut_raw, cut_floor, cut_clamp;
	logic [POS_W-1:0] len;

	always_comb begin
		cut_raw   = ((min_pos_s2 != '0) && (prefix_s2 > min_prefix_s2))
			? CUT_W'(min_pos_s2) : '0;
		cut_floor = (cut_raw < CUT_W'(MIN_KEEP)) ? CUT_W'(MIN_KEEP) : cut_raw;
		cut_clamp = (cut_floor > CUT_W'(pos_s2)) ? CUT_W'(pos_s2) : cut_floor;
		len       = keep_all_s2 ? pos_s2 : POS_W'(cut_clamp);
	end

	always_ff @(posedge clk) begin
		if (step) begin
			quality_out_s3 <= quality_out_s2;
			trim_valid_s3  <= last_s2;
			trim_length_s3 <= last_s2 ? LEN_W'(len) : '0;
		end
	end

endmodule

### rtl/core/quality_tail_trimmer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quality_tail_trimmer_top
// 3-prime quality trimming of a read streamed one quality character at a
// time; config registers, input register and three-stage valid pipeline.
// ----------------------------------------------------------------------------
// pipeline: three register stages, the input register, the accumulator result
// register and the output result register
// throughput: one request per cycle while the output is not stalled, set by
// the combinational sum and minimum update in the accumulator stage
// a stalled result backs up the stages; input is held off once all three are full
// reset: asynchronous, clears config, pipeline valids and per-read state
module quality_tail_trimmer_top #(
	parameter int MAX_LEN  = qtt_pkg::MAX_LEN_DEFAULT,
	parameter int MIN_KEEP = qtt_pkg::MIN_KEEP_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qtt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qtt_pkg::CFG_W-1:0]      cfg_data,
	qtt_in_if.sink                         in_ch,
	qtt_out_if.source                      out_ch
);
	import qtt_pkg::*;

	localparam int SUM_W = $clog2(MAX_LEN) + QCHAR_W + 1;
	localparam int POS_W = $clog2(MAX_LEN + 1);

	cfg_t                    cfg_q;
	logic                    v_s1, v_s2, v_s3;
	logic                    en_s1, en_s2, en_s3;
	logic [QCHAR_W-1:0]      quality_char_s1;
	logic                    last_s1;

	logic [QCHAR_W-1:0]      quality_out_s2;
	logic                    last_s2, keep_all_s2;
	logic signed [SUM_W-1:0] prefix_s2, min_prefix_s2;
	logic [POS_W-1:0]        min_pos_s2, pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRIM_THRESHOLD: cfg_q.trim_threshold <= cfg_data[THR_W-1:0];
				CFG_SANGER_MODE:    cfg_q.sanger_mode    <= cfg_data[0];
			endcase
		end
	end

	assign en_s3 = !v_s3 || out_ch.ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ch.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_ch.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_ch.valid) begin
			quality_char_s1 <= in_ch.quality_char;
			last_s1         <= in_ch.last;
		end
	end

	qtt_accum #(
		.MAX_LEN (MAX_LEN)
	) u_accum (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (v_s1 && en_s2),
		.cfg             (cfg_q),
		.quality_char_s1 (quality_char_s1),
		.last_s1         (last_s1),
		.quality_out_s2  (quality_out_s2),
		.last_s2         (last_s2),
		.keep_all_s2     (keep_all_s2),
		.prefix_s2       (prefix_s2),
		.min_prefix_s2   (min_prefix_s2),
		.min_pos_s2      (min_pos_s2),
		.pos_s2          (pos_s2)
	);

	qtt_len #(
		.MAX_LEN  (MAX_LEN),
		.MIN_KEEP (MIN_KEEP)
	) u_len (
		.clk            (clk),
		.step           (v_s2 && en_s3),
		.quality_out_s2 (quality_out_s2),
		.last_s2        (last_s2),
		.keep_all_s2    (keep_all_s2),
		.prefix_s2      (prefix_s2),
		.min_prefix_s2  (min_prefix_s2),
		.min_pos_s2     (min_pos_s2),
		.pos_s2         (pos_s2),
		.quality_out_s3 (out_ch.quality_out),
		.trim_valid_s3  (out_ch.trim_valid),
		.trim_length_s3 (out_ch.trim_length)
	);

	assign out_ch.valid = v_s3;

endmodule

### tb/quality_tail_trimmer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quality_tail_trimmer_top_test
// Streams reads of quality characters through the trimmer under several
// threshold and offset settings. A scoreboard predicts the converted character
// and the kept length of every read and checks each response in order, while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module quality_tail_trimmer_top_test;
	import qtt_pkg::*;

	localparam int MAX_LEN       = MAX_LEN_DEFAULT;
	localparam int MIN_KEEP      = MIN_KEEP_DEFAULT;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int STEADY_FROM   = 1750;
	localparam int LONG_HOLD     = 300;

	typedef struct packed {
		logic [QCHAR_W-1:0] quality_out;
		logic               trim_valid;
		logic [LEN_W-1:0]   trim_length;
	} trim_result_t;

	class trim_scoreboard;
		logic [THR_W-1:0]   threshold;
		logic               sanger;
		logic signed [18:0] prefix_sum;
		logic signed [18:0] min_prefix;
		logic [LEN_W-1:0]   min_pos;
		logic [LEN_W-1:0]   read_pos;
		trim_result_t       expected_q[$];
		int errors;
		int checked;
		int reads;
		int trimmed;

		function new();
			threshold = '0;
			sanger = 1'b0;
			clear_read();
		endfunction

		function void clear_read();
			prefix_sum = '0;
			min_prefix = '0;
			min_pos = '0;
			read_pos = '0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// predicts the response to one accepted request
		function void note_request(logic [QCHAR_W-1:0] ch, logic last);
			int q;
			int sum;
			int cut;
			trim_result_t r;
			q = int'(ch) - (sanger ? int'(OFFSET_SANGER) : int'(OFFSET_STD));
			r.quality_out = sanger ? ch - SANGER_SHIFT : ch;
			r.trim_valid = last;
			r.trim_length = '0;
			if (read_pos < MAX_LEN) begin
				if (read_pos >= 1 && (min_pos == 0 || prefix_sum < min_prefix)) begin
					min_prefix = prefix_sum;
					min_pos = read_pos;
				end
				sum = int'(prefix_sum) + int'(threshold) - q;
				prefix_sum = sum[18:0];
				read_pos++;
			end
			if (last) begin
				reads++;
				if (threshold == 0 || q >= int'(threshold)) begin
					r.trim_length = read_pos;
				end else begin
					cut = 0;
					if (min_pos != 0 && int'(prefix_sum) - int'(min_prefix) > 0)
						cut = min_pos;
					if (cut < MIN_KEEP)
						cut = MIN_KEEP;
					if (cut > read_pos)
						cut = read_pos;
					r.trim_length = cut[LEN_W-1:0];
					if (cut < read_pos)
						trimmed++;
				end
				clear_read();
			end
			expected_q.push_back(r);
		endfunction

		function void report(string field, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
			errors++;
			if (errors <= 100)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(trim_result_t got);
			trim_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected response, expected none, actual %h %b %0d", $time,
					got.quality_out, got.trim_valid, got.trim_length);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.quality_out !== want.quality_out)
				report("quality_out", want.quality_out, got.quality_out);
			if (got.trim_valid !== want.trim_valid)
				report("trim_valid", want.trim_valid, got.trim_valid);
			if (got.trim_length !== want.trim_length)
				report("trim_length", want.trim_length, got.trim_length);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	qtt_in_if  in_ch();
	qtt_out_if out_ch();

	quality_tail_trimmer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	trim_scoreboard sb = new();
	int  n_sent;
	int  cycles;
	bit  steady;
	bit  held_once;
	int  stall_left;
	int  overlong_reads;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("RESULT: ERROR");
		$finish;
	end

	// response side: checks accepted responses, stalls in bursts
	initial begin
		trim_result_t got;
		out_ch.ready <= 1'b0;
		stall_left = 0;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ch.ready <= 1'b0;
			end else begin
				if (out_ch.valid && out_ch.ready) begin
					got.quality_out = out_ch.quality_out;
					got.trim_valid = out_ch.trim_valid;
					got.trim_length = out_ch.trim_length;
					sb.check_result(got);
				end
				if (!held_once && sb.checked >= 400) begin
					held_once = 1'b1;
					stall_left = LONG_HOLD;
				end
				if (stall_left > 0) begin
					stall_left--;
					out_ch.ready <= 1'b0;
				end else if (!steady && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 9) - 1;
					out_ch.ready <= 1'b0;
				end else begin
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	task automatic set_config(logic [THR_W-1:0] thr, logic sanger_mode);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TRIM_THRESHOLD;
		cfg_data <= CFG_W'(thr);
		@(posedge clk);
		cfg_index <= CFG_SANGER_MODE;
		cfg_data <= CFG_W'(sanger_mode);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = thr;
		sb.sanger = sanger_mode;
	endtask

	task automatic send_item(logic [QCHAR_W-1:0] ch, logic last);
		in_ch.valid <= 1'b1;
		in_ch.quality_char <= ch;
		in_ch.last <= last;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(ch, last);
		n_sent++;
		if (n_sent >= STEADY_FROM)
			steady = 1'b1;
		if (!steady && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// well-formed reads have a good head and a poor tail; some are noise or ties
	task automatic send_read(int len);
		int kind;
		int tail_at;
		int base;
		int thr;
		int v;
		kind = $urandom_range(0, 9);
		tail_at = $urandom_range(0, len);
		base = sb.sanger ? int'(OFFSET_SANGER) : int'(OFFSET_STD);
		thr = sb.threshold;
		for (int i = 0; i < len; i++) begin
			if (kind == 0)
				v = $urandom_range(0, 255);
			else if (kind == 1)
				v = base + thr;
			else if (i < tail_at && $urandom_range(0, 7) != 0)
				v = base + thr + $urandom_range(0, 20);
			else
				v = base + $urandom_range(0, thr + 2) - 2;
			send_item(v[QCHAR_W-1:0], i == len - 1);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int targets[5];
		logic [THR_W-1:0] thrs[5];
		logic sangers[5];
		int len;
		int pick;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.quality_char <= '0;
		in_ch.last <= 1'b0;
		n_sent = 0;
		steady = 1'b0;
		overlong_reads = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(7'd30, 1'b0);
		send_item(8'd0, 1'b1);
		send_item(8'd255, 1'b1);
		send_item(8'd73, 1'b0);
		send_item(8'd35, 1'b0);
		send_item(8'd35, 1'b1);
		send_item(8'd63, 1'b0);
		send_item(8'd63, 1'b0);
		send_item(8'd63, 1'b0);
		send_item(8'd63, 1'b1);
		send_item(8'd34, 1'b0);
		send_item(8'd128, 1'b0);
		send_item(8'd63, 1'b1);
		drain();

		targets = '{320, 1480, 1640, 1800, 1960};
		thrs = '{7'd0, 7'd93, THR_W'($urandom_range(2, 92)), 7'd1,
			THR_W'($urandom_range(1, 92))};
		sangers = '{1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1))};
		for (int p = 0; p < 5; p++) begin
			set_config(thrs[p], sangers[p]);
			if (p == 1) begin
				send_read(MAX_LEN + $urandom_range(1, 8));
				overlong_reads++;
			end
			while (n_sent < targets[p]) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					len = $urandom_range(1, 8);
				else if (pick < 7)
					len = $urandom_range(30, 45);
				else
					len = $urandom_range(46, 90);
				send_read(len);
			end
			drain();
		end

		$display("checked %0d responses over %0d reads, %0d of them cut short", sb.checked,
			sb.reads, sb.trimmed);
		$display("thresholds 0 to 93, both offsets, %0d read past the length limit",
			overlong_reads);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/core/qtt_pkg.sv
rtl/core/qtt_if.sv
rtl/core/qtt_accum.sv
rtl/core/qtt_len.sv
rtl/core/quality_tail_trimmer_top.sv
tb/quality_tail_trimmer_top_test.sv
